// File: rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; imported by every module of the block.
`default_nettype none

package ffba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam int HEADER_BYTES = 16;
   localparam int ALIGN        = 8;
   localparam int ALIGN_W      = $clog2(ALIGN);

   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 25;
   localparam int REQ_W   = 24;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_SIZE = 1'd1;

   localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 25'd1048576;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
   localparam logic [1:0] STATUS_BAD_ADDR   = 2'd3;

   typedef struct packed {
      logic              cmd;
      logic [REQ_W-1:0]  req_size;
      logic [ADDR_W-1:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic hit_take;
      logic miss_take;
      logic zero_take;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic free_zero;
      logic out_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
// First-fit block allocator over a heap region, top level.
// Depends on ffba_pkg, ffba_controller and ffba_datapath.
//
// Usage:
//   csr_*  : write heap_base (index 0) or the region size (index 1) while idle.
//   req_*  : one item per allocate (cmd 0, req_size) or free (cmd 1, free_addr).
//   rsp_*  : one item per request: granted payload address and status.
// Timing: the table memory is read one entry per cycle and the scan stops
//   at the first fitting or matching block. A free of address zero skips
//   the scan. The next item can be accepted in the same cycle that rsp_valid
//   rises; one item may wait at the output while the next is scanned.
// Reset: the table empties, heap_base goes to 0 and the region size to 1 MiB;
//   the block accepts items in the first cycle after reset.
// Stall: while rsp_ready is low the result holds, and a finished follow-on
//   item waits inside until the output register frees.
`default_nettype none

module first_fit_block_allocator (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_wr_en,
   input  wire  [ffba_pkg::CSR_IDX_W-1:0]  csr_wr_idx,
   input  wire  [ffba_pkg::CSR_W-1:0]      csr_wr_data,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  ffba_pkg::req_type         req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output ffba_pkg::rsp_type               rsp_data
);
   import ffba_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   ffba_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   ffba_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_idx  (csr_wr_idx),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .ctl_cmd     (ctl_cmd),
      .dp_stat     (dp_stat),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl_cmd.out_load |-> !(rsp_valid && !rsp_ready))
      else $error("result overwritten while waiting at output");

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.addr == '0))
      else $error("failed item carries non-zero address");

   a_single_take: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl_cmd.hit_take, ctl_cmd.miss_take, ctl_cmd.zero_take}) <= 1)
      else $error("more than one result captured in a cycle");

endmodule

`default_nettype wire

// File: rtl/ffba_datapath.sv
// Datapath: block table memories, free marks, scan pipeline, result registers.
// Depends on ffba_pkg; driven by ffba_controller.
`default_nettype none

module ffba_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_wr_en,
   input  wire  [ffba_pkg::CSR_IDX_W-1:0]    csr_wr_idx,
   input  wire  [ffba_pkg::CSR_W-1:0]        csr_wr_data,
   input  wire  ffba_pkg::req_type           req_data,
   input  wire  ffba_pkg::ctl_cmd_type       ctl_cmd,
   output ffba_pkg::dp_stat_type             dp_stat,
   input  wire                               rsp_ready,
   output logic                              rsp_valid,
   output ffba_pkg::rsp_type                 rsp_data
);
   import ffba_pkg::*;

   logic [SIZE_W-1:0] offset_mem  [MAX_BLOCKS];
   logic [SIZE_W-1:0] payload_mem [MAX_BLOCKS];

   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [MAX_BLOCKS-1:0] free_ff, free_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SIZE_W-1:0]     tail_ff, tail_in;
   req_type               cur_ff, cur_in;
   logic [SIZE_W-1:0]     need_ff, need_in;
   logic [ADDR_W-1:0]     target_ff, target_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;
   logic [SIZE_W-1:0]     off_rd_ff;
   logic [SIZE_W-1:0]     pay_rd_ff;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  issue;
   logic                  match;
   logic                  append;
   logic [SIZE_W:0]       new_end;
   logic [SIZE_W:0]       round_sum;

   assign issue = ctl_cmd.scan && (rd_idx_ff < count_ff);
   assign match = (cur_ff.cmd == CMD_FREE)
                ? ({{(ADDR_W-SIZE_W){1'b0}}, off_rd_ff} == target_ff)
                : (free_ff[chk_idx_ff] && (pay_rd_ff >= need_ff));
   assign new_end = {1'b0, tail_ff} + (SIZE_W+1)'(HEADER_BYTES) + {1'b0, need_ff};
   assign round_sum = (SIZE_W+1)'(req_data.req_size) + (SIZE_W+1)'(ALIGN - 1);
   assign append = ctl_cmd.miss_take && (cur_ff.cmd == CMD_ALLOC)
                 && (new_end <= {1'b0, size_ff})
                 && (count_ff < CNT_W'(MAX_BLOCKS));

   assign dp_stat.hit       = chk_valid_ff && match;
   assign dp_stat.exhausted = !chk_valid_ff && (rd_idx_ff >= count_ff);
   assign dp_stat.free_zero = (cur_ff.cmd == CMD_FREE) && (cur_ff.free_addr == '0);
   assign dp_stat.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      base_in      = base_ff;
      size_in      = size_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      tail_in      = tail_ff;
      cur_in       = cur_ff;
      need_in      = need_ff;
      target_in    = target_ff;
      rd_idx_in    = rd_idx_ff;
      chk_valid_in = issue;
      chk_idx_in   = rd_idx_ff[IDX_W-1:0];
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_wr_en) begin
         unique case (csr_wr_idx)
            CSR_HEAP_BASE: base_in = csr_wr_data;
            CSR_HEAP_SIZE: size_in = csr_wr_data[SIZE_W-1:0];
            default: ;
         endcase
      end

      if (ctl_cmd.start) begin
         cur_in    = req_data;
         need_in   = {round_sum[SIZE_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
         target_in = req_data.free_addr - base_ff - ADDR_W'(HEADER_BYTES);
         rd_idx_in = '0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      if (ctl_cmd.hit_take) begin
         if (cur_ff.cmd == CMD_FREE) begin
            free_in[chk_idx_ff] = 1'b1;
            res_in = '{addr: '0, status: STATUS_OK};
         end else begin
            free_in[chk_idx_ff] = 1'b0;
            res_in.addr   = base_ff + {{(ADDR_W-SIZE_W){1'b0}}, off_rd_ff}
                          + ADDR_W'(HEADER_BYTES);
            res_in.status = STATUS_OK;
         end
      end

      if (ctl_cmd.miss_take) begin
         if (cur_ff.cmd == CMD_FREE) begin
            res_in = '{addr: '0, status: STATUS_BAD_ADDR};
         end else if (new_end > {1'b0, size_ff}) begin
            res_in = '{addr: '0, status: STATUS_NO_SPACE};
         end else if (!append) begin
            res_in = '{addr: '0, status: STATUS_TABLE_FULL};
         end else begin
            free_in[count_ff[IDX_W-1:0]] = 1'b0;
            count_in = count_ff + 1'b1;
            tail_in  = new_end[SIZE_W-1:0];
            res_in.addr   = base_ff + {{(ADDR_W-SIZE_W){1'b0}}, tail_ff}
                          + ADDR_W'(HEADER_BYTES);
            res_in.status = STATUS_OK;
         end
      end

      if (ctl_cmd.zero_take) begin
         res_in = '{addr: '0, status: STATUS_OK};
      end

      if (ctl_cmd.out_load) begin
         rsp_data_in  = res_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         size_ff      <= HEAP_SIZE_RESET;
         free_ff      <= '0;
         count_ff     <= '0;
         tail_ff      <= '0;
         rd_idx_ff    <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         size_ff      <= size_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         rd_idx_ff    <= rd_idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      need_ff     <= need_in;
      target_ff   <= target_in;
      chk_idx_ff  <= chk_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // block table: one write port (append), one registered read port (scan)
   always_ff @(posedge clock) begin
      if (append) begin
         offset_mem[count_ff[IDX_W-1:0]]  <= tail_ff;
         payload_mem[count_ff[IDX_W-1:0]] <= need_ff;
      end
      off_rd_ff <= offset_mem[rd_idx_ff[IDX_W-1:0]];
      pay_rd_ff <= payload_mem[rd_idx_ff[IDX_W-1:0]];
   end

endmodule

`default_nettype wire

// File: rtl/ffba_controller.sv
// Controller: sequences accept, table scan, result capture and hand-off.
// Depends on ffba_pkg; drives ffba_datapath.
`default_nettype none

module ffba_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire ffba_pkg::dp_stat_type dp_stat,
   output ffba_pkg::ctl_cmd_type   ctl_cmd
);
   import ffba_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctl_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.start = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (dp_stat.free_zero) begin
               ctl_cmd.zero_take = 1'b1;
               state_in          = ST_HOLD;
            end else if (dp_stat.hit) begin
               ctl_cmd.scan     = 1'b1;
               ctl_cmd.hit_take = 1'b1;
               state_in         = ST_HOLD;
            end else if (dp_stat.exhausted) begin
               ctl_cmd.scan      = 1'b1;
               ctl_cmd.miss_take = 1'b1;
               state_in          = ST_HOLD;
            end else begin
               ctl_cmd.scan = 1'b1;
            end
         end
         ST_HOLD: begin
            if (!dp_stat.out_busy) begin
               ctl_cmd.out_load = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
